// ===== src/sia_pkg.sv =====
// Shared constants, types and codes of the segment intersection unit.
`default_nettype none
package sia_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int XY_BITS    = 24;

  localparam int DW   = COORD_BITS + 1;
  localparam int MW   = 2 * DW;
  localparam int PMW  = 2 * COORD_BITS;
  localparam int DETW = 2 * COORD_BITS + 3;
  localparam int PW   = 2 * COORD_BITS + 1;
  localparam int TW   = PW + DW;
  localparam int NW   = 3 * COORD_BITS + 4;
  localparam int EPW  = COORD_BITS + DETW + 1;
  localparam int UW   = 3 * COORD_BITS + 3;
  localparam int RW   = UW + FRAC_BITS;
  localparam int QW   = COORD_BITS + FRAC_BITS;
  localparam int SW   = COORD_BITS + FRAC_BITS + 1;
  localparam int EW   = (SW > XY_BITS) ? SW : XY_BITS;

  typedef enum logic [1:0] {
    OUT_CROSS    = 2'd0,
    OUT_PARALLEL = 2'd1,
    OUT_OUTSIDE  = 2'd2
  } outcome_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] x2;
    logic signed [COORD_BITS-1:0] y2;
    logic signed [COORD_BITS-1:0] x3;
    logic signed [COORD_BITS-1:0] y3;
    logic signed [COORD_BITS-1:0] x4;
    logic signed [COORD_BITS-1:0] y4;
  } pts_t;

  typedef struct packed {
    logic                         hit;
    outcome_e                     outcome;
    logic signed [COORD_BITS-1:0] lox;
    logic signed [COORD_BITS-1:0] loy;
    logic [DETW-1:0]              den;
  } side_t;

  typedef struct packed {
    logic            valid;
    side_t           side;
    logic [UW-1:0]   num_x;
    logic [UW-1:0]   num_y;
  } div_in_t;

  typedef struct packed {
    logic          valid;
    side_t         side;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
  } div_out_t;

endpackage
`default_nettype wire

// ===== src/sia_in_if.sv =====
// Input channel carrying the endpoints of two segments.
`default_nettype none
interface sia_in_if;
  logic valid;
  logic ready;
  logic signed [sia_pkg::COORD_BITS-1:0] a_start_x;
  logic signed [sia_pkg::COORD_BITS-1:0] a_start_y;
  logic signed [sia_pkg::COORD_BITS-1:0] a_end_x;
  logic signed [sia_pkg::COORD_BITS-1:0] a_end_y;
  logic signed [sia_pkg::COORD_BITS-1:0] b_start_x;
  logic signed [sia_pkg::COORD_BITS-1:0] b_start_y;
  logic signed [sia_pkg::COORD_BITS-1:0] b_end_x;
  logic signed [sia_pkg::COORD_BITS-1:0] b_end_y;

  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface
`default_nettype wire

// ===== src/sia_out_if.sv =====
// Output channel carrying one intersection result.
`default_nettype none
interface sia_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [1:0] outcome;
  logic signed [sia_pkg::XY_BITS-1:0] cross_x;
  logic signed [sia_pkg::XY_BITS-1:0] cross_y;

  modport source (output valid, hit, outcome, cross_x, cross_y, input ready);
  modport sink   (input valid, hit, outcome, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

// ===== src/sia_geom.sv =====
// Six-stage determinant, numerator and bounding box pipeline.
`default_nettype none
module sia_geom (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             valid_i,
  input  sia_pkg::pts_t         pts_i,
  output sia_pkg::div_in_t      div_o
);

  // Stage A: differences and first products.
  logic [5:0] v_q;
  sia_pkg::pts_t pa_q, pb_q, pc_q;
  logic signed [sia_pkg::DW-1:0] dxa_d, dya_d, dxb_d, dyb_d;
  logic signed [sia_pkg::DW-1:0] dxa_q, dya_q, dxb_q, dyb_q;
  logic signed [sia_pkg::DW-1:0] dxa2_q, dya2_q, dxb2_q, dyb2_q;
  logic signed [sia_pkg::MW-1:0] m0_q, m1_q;
  logic signed [sia_pkg::PMW-1:0] m2_q, m3_q, m4_q, m5_q;

  assign dxa_d = sia_pkg::DW'(pts_i.x1) - sia_pkg::DW'(pts_i.x2);
  assign dya_d = sia_pkg::DW'(pts_i.y1) - sia_pkg::DW'(pts_i.y2);
  assign dxb_d = sia_pkg::DW'(pts_i.x3) - sia_pkg::DW'(pts_i.x4);
  assign dyb_d = sia_pkg::DW'(pts_i.y3) - sia_pkg::DW'(pts_i.y4);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pa_q  <= pts_i;
      dxa_q <= dxa_d;
      dya_q <= dya_d;
      dxb_q <= dxb_d;
      dyb_q <= dyb_d;
      m0_q  <= sia_pkg::MW'(dxa_d) * sia_pkg::MW'(dyb_d);
      m1_q  <= sia_pkg::MW'(dya_d) * sia_pkg::MW'(dxb_d);
      m2_q  <= sia_pkg::PMW'(pts_i.x1) * sia_pkg::PMW'(pts_i.y2);
      m3_q  <= sia_pkg::PMW'(pts_i.y1) * sia_pkg::PMW'(pts_i.x2);
      m4_q  <= sia_pkg::PMW'(pts_i.x3) * sia_pkg::PMW'(pts_i.y4);
      m5_q  <= sia_pkg::PMW'(pts_i.y3) * sia_pkg::PMW'(pts_i.x4);
    end
  end

  // Stage B: determinant and the two cross terms.
  logic signed [sia_pkg::DETW-1:0] detb_q, detc_q;
  logic signed [sia_pkg::PW-1:0]   pab_q, pbb_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pb_q   <= pa_q;
      dxa2_q <= dxa_q;
      dya2_q <= dya_q;
      dxb2_q <= dxb_q;
      dyb2_q <= dyb_q;
      detb_q <= sia_pkg::DETW'(m0_q) - sia_pkg::DETW'(m1_q);
      pab_q  <= sia_pkg::PW'(m2_q) - sia_pkg::PW'(m3_q);
      pbb_q  <= sia_pkg::PW'(m4_q) - sia_pkg::PW'(m5_q);
    end
  end

  // Stage C: numerator products.
  logic signed [sia_pkg::TW-1:0] t0_q, t1_q, t2_q, t3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pc_q   <= pb_q;
      detc_q <= detb_q;
      t0_q   <= sia_pkg::TW'(pab_q) * sia_pkg::TW'(dxb2_q);
      t1_q   <= sia_pkg::TW'(dxa2_q) * sia_pkg::TW'(pbb_q);
      t2_q   <= sia_pkg::TW'(pab_q) * sia_pkg::TW'(dyb2_q);
      t3_q   <= sia_pkg::TW'(dya2_q) * sia_pkg::TW'(pbb_q);
    end
  end

  // Stage D: numerators normalized to a positive denominator, box limits.
  logic signed [sia_pkg::NW-1:0] nx_d, ny_d, nxd_q, nyd_q, nxe_q, nye_q;
  logic [sia_pkg::DETW-1:0] dend_q, dene_q;
  logic pard_q, pare_q;
  logic signed [sia_pkg::COORD_BITS-1:0] lo_ax_q, hi_ax_q, lo_bx_q, hi_bx_q;
  logic signed [sia_pkg::COORD_BITS-1:0] lo_ay_q, hi_ay_q, lo_by_q, hi_by_q;

  assign nx_d = sia_pkg::NW'(t0_q) - sia_pkg::NW'(t1_q);
  assign ny_d = sia_pkg::NW'(t2_q) - sia_pkg::NW'(t3_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      nxd_q   <= detc_q[sia_pkg::DETW-1] ? -nx_d : nx_d;
      nyd_q   <= detc_q[sia_pkg::DETW-1] ? -ny_d : ny_d;
      dend_q  <= detc_q[sia_pkg::DETW-1] ? sia_pkg::DETW'(-detc_q)
                                          : sia_pkg::DETW'(detc_q);
      pard_q  <= (detc_q == '0);
      lo_ax_q <= (pc_q.x1 < pc_q.x2) ? pc_q.x1 : pc_q.x2;
      hi_ax_q <= (pc_q.x1 < pc_q.x2) ? pc_q.x2 : pc_q.x1;
      lo_bx_q <= (pc_q.x3 < pc_q.x4) ? pc_q.x3 : pc_q.x4;
      hi_bx_q <= (pc_q.x3 < pc_q.x4) ? pc_q.x4 : pc_q.x3;
      lo_ay_q <= (pc_q.y1 < pc_q.y2) ? pc_q.y1 : pc_q.y2;
      hi_ay_q <= (pc_q.y1 < pc_q.y2) ? pc_q.y2 : pc_q.y1;
      lo_by_q <= (pc_q.y3 < pc_q.y4) ? pc_q.y3 : pc_q.y4;
      hi_by_q <= (pc_q.y3 < pc_q.y4) ? pc_q.y4 : pc_q.y3;
    end
  end

  // Stage E: box limits scaled by the denominator.
  logic signed [sia_pkg::DETW:0] dens;
  logic signed [sia_pkg::EPW-1:0] plax_q, phax_q, plbx_q, phbx_q;
  logic signed [sia_pkg::EPW-1:0] play_q, phay_q, plby_q, phby_q;
  logic signed [sia_pkg::COORD_BITS-1:0] lox_q, loy_q;

  assign dens = $signed({1'b0, dend_q});

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      nxe_q  <= nxd_q;
      nye_q  <= nyd_q;
      dene_q <= dend_q;
      pare_q <= pard_q;
      lox_q  <= lo_ax_q;
      loy_q  <= lo_ay_q;
      plax_q <= sia_pkg::EPW'(lo_ax_q) * sia_pkg::EPW'(dens);
      phax_q <= sia_pkg::EPW'(hi_ax_q) * sia_pkg::EPW'(dens);
      plbx_q <= sia_pkg::EPW'(lo_bx_q) * sia_pkg::EPW'(dens);
      phbx_q <= sia_pkg::EPW'(hi_bx_q) * sia_pkg::EPW'(dens);
      play_q <= sia_pkg::EPW'(lo_ay_q) * sia_pkg::EPW'(dens);
      phay_q <= sia_pkg::EPW'(hi_ay_q) * sia_pkg::EPW'(dens);
      plby_q <= sia_pkg::EPW'(lo_by_q) * sia_pkg::EPW'(dens);
      phby_q <= sia_pkg::EPW'(hi_by_q) * sia_pkg::EPW'(dens);
    end
  end

  // Stage F: exact box tests and offsets from the lower x and y limits.
  logic outside;
  sia_pkg::side_t side_q;
  logic [sia_pkg::UW-1:0] numx_q, numy_q;
  logic signed [sia_pkg::NW-1:0] offx, offy;

  assign outside = (nxe_q < plax_q) || (nxe_q > phax_q) ||
                   (nxe_q < plbx_q) || (nxe_q > phbx_q) ||
                   (nye_q < play_q) || (nye_q > phay_q) ||
                   (nye_q < plby_q) || (nye_q > phby_q);
  assign offx = nxe_q - plax_q;
  assign offy = nye_q - play_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q.hit <= !pare_q && !outside;
      if (pare_q) begin
        side_q.outcome <= sia_pkg::OUT_PARALLEL;
      end else if (outside) begin
        side_q.outcome <= sia_pkg::OUT_OUTSIDE;
      end else begin
        side_q.outcome <= sia_pkg::OUT_CROSS;
      end
      side_q.lox <= lox_q;
      side_q.loy <= loy_q;
      side_q.den <= dene_q;
      numx_q     <= sia_pkg::UW'(offx);
      numy_q     <= sia_pkg::UW'(offy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  assign div_o.valid = v_q[5];
  assign div_o.side  = side_q;
  assign div_o.num_x = numx_q;
  assign div_o.num_y = numy_q;

endmodule
`default_nettype wire

// ===== src/sia_div.sv =====
// Pipelined restoring divider, one quotient bit per stage for x and y.
`default_nettype none
module sia_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  sia_pkg::div_in_t   div_i,
  output sia_pkg::div_out_t  div_o
);

  localparam int RW = sia_pkg::RW;
  localparam int QW = sia_pkg::QW;

  logic [QW-1:0]   v_q;
  logic [RW-1:0]   rx_q [QW];
  logic [RW-1:0]   ry_q [QW];
  logic [QW-1:0]   qx_q [QW];
  logic [QW-1:0]   qy_q [QW];
  sia_pkg::side_t  sd_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic [RW-1:0]  rx_in, ry_in;
    logic [QW-1:0]  qx_in, qy_in;
    sia_pkg::side_t sd_in;
    logic [RW:0]    dsh, tx, ty;

    if (i == 0) begin : g_first
      assign rx_in = RW'(div_i.num_x) << sia_pkg::FRAC_BITS;
      assign ry_in = RW'(div_i.num_y) << sia_pkg::FRAC_BITS;
      assign qx_in = '0;
      assign qy_in = '0;
      assign sd_in = div_i.side;
    end else begin : g_next
      assign rx_in = rx_q[i-1];
      assign ry_in = ry_q[i-1];
      assign qx_in = qx_q[i-1];
      assign qy_in = qy_q[i-1];
      assign sd_in = sd_q[i-1];
    end

    assign dsh = (RW + 1)'(sd_in.den) << K;
    assign tx  = {1'b0, rx_in} - dsh;
    assign ty  = {1'b0, ry_in} - dsh;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rx_q[i] <= tx[RW] ? rx_in : tx[RW-1:0];
        ry_q[i] <= ty[RW] ? ry_in : ty[RW-1:0];
        qx_q[i] <= qx_in | (QW'(!tx[RW]) << K);
        qy_q[i] <= qy_in | (QW'(!ty[RW]) << K);
        sd_q[i] <= sd_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= QW'({v_q, div_i.valid});
    end
  end

  assign div_o.valid = v_q[QW-1];
  assign div_o.side  = sd_q[QW-1];
  assign div_o.q_x   = qx_q[QW-1];
  assign div_o.q_y   = qy_q[QW-1];

endmodule
`default_nettype wire

// ===== src/segment_intersection_unit.sv =====
// Throughput: one item per cycle; the whole pipeline advances together and
// holds in place while a finished result waits to be taken.
// Each item passes through the six geometry stages, one divider stage per
// quotient bit (24) and the output register. Reset clears only valid bits.
`default_nettype none
module segment_intersection_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sia_in_if.sink    in_i,
  sia_out_if.source out_o
);

  logic              adv;
  sia_pkg::pts_t     pts;
  sia_pkg::div_in_t  div_in;
  sia_pkg::div_out_t div_out;

  logic                                  out_valid_q;
  logic                                  hit_q;
  logic [1:0]                            outcome_q;
  logic signed [sia_pkg::XY_BITS-1:0]    cx_q, cy_q;
  logic signed [sia_pkg::EW-1:0]         sx, sy;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  assign pts.x1 = in_i.a_start_x;
  assign pts.y1 = in_i.a_start_y;
  assign pts.x2 = in_i.a_end_x;
  assign pts.y2 = in_i.a_end_y;
  assign pts.x3 = in_i.b_start_x;
  assign pts.y3 = in_i.b_start_y;
  assign pts.x4 = in_i.b_end_x;
  assign pts.y4 = in_i.b_end_y;

  sia_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_i.valid),
    .pts_i   (pts),
    .div_o   (div_in)
  );

  sia_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .div_i  (div_in),
    .div_o  (div_out)
  );

  // The quotient is the offset from the lower box limit of segment A.
  assign sx = (sia_pkg::EW'(div_out.side.lox) <<< sia_pkg::FRAC_BITS) +
              sia_pkg::EW'({1'b0, div_out.q_x});
  assign sy = (sia_pkg::EW'(div_out.side.loy) <<< sia_pkg::FRAC_BITS) +
              sia_pkg::EW'({1'b0, div_out.q_y});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q     <= div_out.side.hit;
      outcome_q <= div_out.side.outcome;
      cx_q      <= div_out.side.hit ? sx[sia_pkg::XY_BITS-1:0] : '0;
      cy_q      <= div_out.side.hit ? sy[sia_pkg::XY_BITS-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_out.valid;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.hit     = hit_q;
  assign out_o.outcome = outcome_q;
  assign out_o.cross_x = cx_q;
  assign out_o.cross_y = cy_q;

endmodule
`default_nettype wire
